// ===== rtl/lpwa_pkg.sv =====
// ----------------------------------------------------------------------------
// lpwa_pkg
// Shared constants and types of the light-pen window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package lpwa_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned AVG_SHIFT = 8;

  localparam int unsigned BTN_RIGHT_BIT  = 1;
  localparam int unsigned BTN_MIDDLE_BIT = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_WINDOW_COUNT = 2'd0;
  localparam cfg_idx_t CFG_RIGHT_MASK   = 2'd1;
  localparam cfg_idx_t CFG_MIDDLE_MASK  = 2'd2;

  localparam logic [CNT_W-1:0]     WINDOW_COUNT_RST = 4'd4;
  localparam logic [CFG_DAT_W-1:0] RIGHT_MASK_RST   = 16'h0400;
  localparam logic [CFG_DAT_W-1:0] MIDDLE_MASK_RST  = 16'h0100;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ===== rtl/light_pen_window_averager.sv =====
// ----------------------------------------------------------------------------
// light_pen_window_averager
// Frame-tick light-pen smoother: windowed position sums, shared serial
// divider for the averages, button decode from the pot-port word.
// ----------------------------------------------------------------------------
//  chan | dir | handshake           | payload
//  in_  | in  | in_valid/in_ready   | in_pen_triggered, in_pen_x, in_pen_y, in_pot_bits
//  out_ | out | out_valid/out_ready | out_report_x, out_report_y, out_report_valid,
//       |     |                     | out_buttons
//  cfg_ | in  | cfg_we              | cfg_index, cfg_data
//
//  A sampling tick updates the window state at accept; the result word is registered at accept.
//  An averaging tick with triggers runs the shared restoring divider
//  on x, then on y; no new word is taken until both are done.
//  An averaging tick without triggers zeroes the averages and skips the divider.
//  A new word is taken while the result is held, once the output register
//  empties in the same cycle or earlier. rst_n is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module light_pen_window_averager (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire lpwa_pkg::cfg_idx_t     cfg_index,
  input  wire [lpwa_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_pen_triggered,
  input  wire signed [15:0]           in_pen_x,
  input  wire signed [15:0]           in_pen_y,
  input  wire [15:0]                  in_pot_bits,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [15:0]          out_report_x,
  output logic signed [15:0]          out_report_y,
  output logic                        out_report_valid,
  output logic [2:0]                  out_buttons
);
  import lpwa_pkg::*;

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t state_r, state_nxt;

  cnt_t window_count_r, window_count_nxt;
  pos_t right_mask_r, right_mask_nxt;
  pos_t middle_mask_r, middle_mask_nxt;

  cnt_t tick_index_r, tick_index_nxt;
  cnt_t hit_count_r, hit_count_nxt;
  pos_t sum_x_r, sum_x_nxt;
  pos_t sum_y_r, sum_y_nxt;
  pos_t avg_x_r, avg_x_nxt;
  pos_t avg_y_r, avg_y_nxt;
  logic avg_valid_r, avg_valid_nxt;

  pos_t div_q_r, div_q_nxt;
  cnt_t div_rem_r, div_rem_nxt;
  cnt_t div_cnt_r, div_cnt_nxt;
  logic div_sel_r, div_sel_nxt;
  logic div_neg_r, div_neg_nxt;

  logic out_valid_r, out_valid_nxt;
  pos_t rep_x_r, rep_x_nxt;
  pos_t rep_y_r, rep_y_nxt;
  logic rep_valid_r, rep_valid_nxt;
  logic [BTN_W-1:0] btn_r, btn_nxt;

  logic in_acc;
  logic avg_tick;
  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] divisor;
  logic fits;
  pos_t q_step;
  pos_t q_signed;
  pos_t avg_val;
  pos_t mag_x;
  pos_t mag_y;
  logic [BTN_W-1:0] btn_dec;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign avg_tick = (tick_index_r == window_count_r);

  assign mag_x = sum_x_r[POS_W-1] ? (~sum_x_r + pos_t'(1)) : sum_x_r;
  assign mag_y = sum_y_r[POS_W-1] ? (~sum_y_r + pos_t'(1)) : sum_y_r;

  // shared restoring divider step
  assign divisor  = {1'b0, hit_count_r};
  assign rem_sh   = {div_rem_r, div_q_r[POS_W-1]};
  assign fits     = (rem_sh >= divisor);
  assign q_step   = {div_q_r[POS_W-2:0], fits};
  assign q_signed = div_neg_r ? (~q_step + pos_t'(1)) : q_step;
  assign avg_val  = {q_signed[POS_W-AVG_SHIFT-1:0], {AVG_SHIFT{1'b0}}};

  always_comb begin
    btn_dec = '0;
    btn_dec[BTN_RIGHT_BIT]  = ((in_pot_bits & right_mask_r) == '0);
    btn_dec[BTN_MIDDLE_BIT] = ((in_pot_bits & middle_mask_r) == '0);
  end

  always_comb begin
    state_nxt        = state_r;
    window_count_nxt = window_count_r;
    right_mask_nxt   = right_mask_r;
    middle_mask_nxt  = middle_mask_r;
    tick_index_nxt   = tick_index_r;
    hit_count_nxt    = hit_count_r;
    sum_x_nxt        = sum_x_r;
    sum_y_nxt        = sum_y_r;
    avg_x_nxt        = avg_x_r;
    avg_y_nxt        = avg_y_r;
    avg_valid_nxt    = avg_valid_r;
    div_q_nxt        = div_q_r;
    div_rem_nxt      = div_rem_r;
    div_cnt_nxt      = div_cnt_r;
    div_sel_nxt      = div_sel_r;
    div_neg_nxt      = div_neg_r;
    out_valid_nxt    = out_valid_r;
    rep_x_nxt        = rep_x_r;
    rep_y_nxt        = rep_y_r;
    rep_valid_nxt    = rep_valid_r;
    btn_nxt          = btn_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_COUNT: window_count_nxt = cfg_data[CNT_W-1:0];
        CFG_RIGHT_MASK:   right_mask_nxt   = cfg_data;
        CFG_MIDDLE_MASK:  middle_mask_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          rep_x_nxt     = avg_x_r;
          rep_y_nxt     = avg_y_r;
          rep_valid_nxt = avg_valid_r;
          btn_nxt       = btn_dec;
          if (avg_tick) begin
            avg_valid_nxt = (hit_count_r >= (window_count_r >> 1));
            if (hit_count_r == '0) begin
              avg_x_nxt      = '0;
              avg_y_nxt      = '0;
              tick_index_nxt = '0;
              sum_x_nxt      = '0;
              sum_y_nxt      = '0;
            end else begin
              state_nxt   = S_DIV;
              div_q_nxt   = mag_x;
              div_neg_nxt = sum_x_r[POS_W-1];
              div_rem_nxt = '0;
              div_cnt_nxt = '0;
              div_sel_nxt = 1'b0;
            end
          end else begin
            tick_index_nxt = tick_index_r + cnt_t'(1);
            if (in_pen_triggered) begin
              hit_count_nxt = hit_count_r + cnt_t'(1);
              sum_x_nxt     = sum_x_r + in_pen_x;
              sum_y_nxt     = sum_y_r + in_pen_y;
            end
          end
        end
      end
      S_DIV: begin
        div_q_nxt   = q_step;
        div_rem_nxt = fits ? cnt_t'(rem_sh - divisor) : rem_sh[CNT_W-1:0];
        div_cnt_nxt = div_cnt_r + cnt_t'(1);
        if (div_cnt_r == '1) begin
          if (!div_sel_r) begin
            // x done, load y
            avg_x_nxt   = avg_val;
            div_q_nxt   = mag_y;
            div_neg_nxt = sum_y_r[POS_W-1];
            div_rem_nxt = '0;
            div_sel_nxt = 1'b1;
          end else begin
            avg_y_nxt      = avg_val;
            tick_index_nxt = '0;
            hit_count_nxt  = '0;
            sum_x_nxt      = '0;
            sum_y_nxt      = '0;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      window_count_r <= WINDOW_COUNT_RST;
      right_mask_r   <= RIGHT_MASK_RST;
      middle_mask_r  <= MIDDLE_MASK_RST;
      tick_index_r   <= '0;
      hit_count_r    <= '0;
      sum_x_r        <= '0;
      sum_y_r        <= '0;
      avg_x_r        <= '0;
      avg_y_r        <= '0;
      avg_valid_r    <= 1'b0;
      div_cnt_r      <= '0;
      div_sel_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      window_count_r <= window_count_nxt;
      right_mask_r   <= right_mask_nxt;
      middle_mask_r  <= middle_mask_nxt;
      tick_index_r   <= tick_index_nxt;
      hit_count_r    <= hit_count_nxt;
      sum_x_r        <= sum_x_nxt;
      sum_y_r        <= sum_y_nxt;
      avg_x_r        <= avg_x_nxt;
      avg_y_r        <= avg_y_nxt;
      avg_valid_r    <= avg_valid_nxt;
      div_cnt_r      <= div_cnt_nxt;
      div_sel_r      <= div_sel_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_neg_r   <= div_neg_nxt;
    rep_x_r     <= rep_x_nxt;
    rep_y_r     <= rep_y_nxt;
    rep_valid_r <= rep_valid_nxt;
    btn_r       <= btn_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_report_x     = rep_x_r;
  assign out_report_y     = rep_y_r;
  assign out_report_valid = rep_valid_r;
  assign out_buttons      = btn_r;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (hit_count_r != '0))
    else $error("divider running with zero trigger count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, div_rem_r} < divisor))
    else $error("divider remainder out of range");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && avg_tick && (hit_count_r != '0)) |=>
      ((state_r == S_DIV) && (div_cnt_r == '0) && !div_sel_r))
    else $error("averaging tick did not start the divider");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the light-pen window averager. A queue of frame
// ticks, register writes and drain points feeds a valid/ready driver; every
// accepted tick is run through a local model of the window sums, the serial
// averages and the button decode, and the monitor compares each result word
// against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import lpwa_pkg::*;

  localparam int ITEM_TARGET    = 1250;
  localparam int IDLE_PCT       = 8;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CALM_LO        = 400;
  localparam int CALM_HI        = 650;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic                 trig;
    logic [15:0]          x;
    logic [15:0]          y;
    logic [15:0]          pot;
    cfg_idx_t             idx;
    logic [CFG_DAT_W-1:0] data;
  } step_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        ok;
    logic [2:0]  btn;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_WINDOW_COUNT;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_pen_triggered = 1'b0;
  logic [15:0]          in_pen_x = '0;
  logic [15:0]          in_pen_y = '0;
  logic [15:0]          in_pot_bits = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          out_report_x;
  logic [15:0]          out_report_y;
  logic                 out_report_valid;
  logic [2:0]           out_buttons;

  light_pen_window_averager dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pen_triggered(in_pen_triggered),
    .in_pen_x        (in_pen_x),
    .in_pen_y        (in_pen_y),
    .in_pot_bits     (in_pot_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_report_x    (out_report_x),
    .out_report_y    (out_report_y),
    .out_report_valid(out_report_valid),
    .out_buttons     (out_buttons)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  step_t   steps[$];
  report_t pending_reports[$];

  int n_sent = 0;
  int n_got = 0;
  int n_cfg = 0;
  int n_means = 0;
  int n_valid_means = 0;
  int errors = 0;
  int quiet = 0;
  int idle_run = 0;
  int stim_items = 0;

  // local copy of the block's registers and window state
  logic [3:0]  win_cnt = WINDOW_COUNT_RST;
  logic [15:0] right_msk = RIGHT_MASK_RST;
  logic [15:0] middle_msk = MIDDLE_MASK_RST;
  logic [3:0]  tick_idx = '0;
  logic [3:0]  hits = '0;
  logic [15:0] acc_x = '0;
  logic [15:0] acc_y = '0;
  logic [15:0] mean_x = '0;
  logic [15:0] mean_y = '0;
  logic        mean_ok = 1'b0;

  function automatic logic [15:0] window_mean(logic [15:0] sum, logic [3:0] cnt);
    int q;
    if (cnt == 4'd0) return '0;
    q = $signed(sum) / $signed({1'b0, cnt});
    return {q[7:0], 8'h00};
  endfunction

  task automatic record_tick(input logic trig, input logic [15:0] px, py, pot);
    report_t r;
    r.x = mean_x;
    r.y = mean_y;
    r.ok = mean_ok;
    r.btn = '0;
    if ((pot & right_msk) == 16'h0) r.btn[BTN_RIGHT_BIT] = 1'b1;
    if ((pot & middle_msk) == 16'h0) r.btn[BTN_MIDDLE_BIT] = 1'b1;
    pending_reports.push_back(r);
    if (tick_idx == win_cnt) begin
      mean_x = window_mean(acc_x, hits);
      mean_y = window_mean(acc_y, hits);
      mean_ok = (hits >= (win_cnt >> 1));
      n_means++;
      if (mean_ok) n_valid_means++;
      tick_idx = '0;
      hits = '0;
      acc_x = '0;
      acc_y = '0;
    end else begin
      tick_idx = tick_idx + 4'd1;
      if (trig) begin
        hits = hits + 4'd1;
        acc_x = acc_x + px;
        acc_y = acc_y + py;
      end
    end
  endtask

  task automatic apply_cfg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_WINDOW_COUNT: win_cnt = data[3:0];
      CFG_RIGHT_MASK:   right_msk = data;
      CFG_MIDDLE_MASK:  middle_msk = data;
      default: ;
    endcase
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string show(report_t r);
    return $sformatf("x=%h y=%h valid=%b buttons=%b", r.x, r.y, r.ok, r.btn);
  endfunction

  task automatic add_item(input logic trig, input logic [15:0] x, y, pot);
    step_t s;
    s.kind = STEP_ITEM;
    s.trig = trig;
    s.x = x;
    s.y = y;
    s.pot = pot;
    s.idx = CFG_WINDOW_COUNT;
    s.data = '0;
    steps.push_back(s);
    stim_items++;
  endtask

  task automatic add_cfg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    step_t s;
    s.kind = STEP_CFG;
    s.trig = 1'b0;
    s.x = '0;
    s.y = '0;
    s.pot = '0;
    s.idx = idx;
    s.data = data;
    steps.push_back(s);
  endtask

  task automatic add_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    s.trig = 1'b0;
    s.x = '0;
    s.y = '0;
    s.pot = '0;
    s.idx = CFG_WINDOW_COUNT;
    s.data = '0;
    steps.push_back(s);
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : drive_words
    step_t s;
    logic  nxt_valid;
    logic  nxt_we;
    nxt_valid = in_valid;
    nxt_we = 1'b0;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      quiet = 0;
    end else begin
      if (in_valid && in_ready) begin
        record_tick(in_pen_triggered, in_pen_x, in_pen_y, in_pot_bits);
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && n_got == n_sent) quiet++;
      else quiet = 0;
      if (!nxt_valid && steps.size() != 0) begin
        s = steps[0];
        case (s.kind)
          STEP_ITEM: begin
            if ((n_sent >= CALM_LO && n_sent < CALM_HI) ||
                $urandom_range(99) >= IDLE_PCT) begin
              in_pen_triggered <= s.trig;
              in_pen_x <= s.x;
              in_pen_y <= s.y;
              in_pot_bits <= s.pot;
              nxt_valid = 1'b1;
              void'(steps.pop_front());
            end
          end
          STEP_CFG: begin
            if (quiet >= SETTLE_CYCLES) begin
              nxt_we = 1'b1;
              cfg_index <= s.idx;
              cfg_data <= s.data;
              apply_cfg(s.idx, s.data);
              n_cfg++;
              void'(steps.pop_front());
            end
          end
          default: begin
            if (n_got == n_sent) void'(steps.pop_front());
          end
        endcase
      end
    end
    in_valid <= nxt_valid;
    cfg_we <= nxt_we;
  end

  // monitor
  always @(posedge clk) begin : check_words
    report_t want;
    report_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.x = out_report_x;
        got.y = out_report_y;
        got.ok = out_report_valid;
        got.btn = out_buttons;
        if (pending_reports.size() == 0) begin
          log_error({"unexpected word: ", show(got)});
        end else begin
          want = pending_reports.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.ok !== want.ok ||
              got.btn !== want.btn)
            log_error($sformatf("word %0d: expected %s, got %s", n_got, show(want),
                                show(got)));
        end
        n_got <= n_got + 1;
      end
      out_ready <= (n_got >= CALM_LO && n_got < CALM_HI) ||
                   $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          len;
    int          trig_pct;
    logic [3:0]  w;
    logic [15:0] rm;
    logic [15:0] mm;
    logic [15:0] pot;

    // default registers: sum overflow, signed extremes, both buttons
    add_item(1'b1, 16'h7FFF, 16'h8000, 16'h0000);
    add_item(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);
    add_item(1'b1, 16'hFFFF, 16'h0001, 16'h0400);
    add_drain();
    add_item(1'b0, 16'h1234, 16'hABCD, 16'h0100);
    add_item(1'b1, 16'h8000, 16'h7FFF, 16'h0500);
    // zero window with zero masks
    add_cfg(CFG_WINDOW_COUNT, 16'd0);
    add_cfg(CFG_RIGHT_MASK, 16'h0000);
    add_cfg(CFG_MIDDLE_MASK, 16'h0000);
    add_item(1'b1, 16'h0100, 16'h0200, 16'hFFFF);
    add_item(1'b0, 16'h0000, 16'h0000, 16'h0000);
    // widest window, then shrink below the tick index so counts wrap
    add_cfg(CFG_WINDOW_COUNT, 16'd15);
    add_cfg(CFG_RIGHT_MASK, 16'hFFFF);
    add_cfg(CFG_MIDDLE_MASK, 16'h8000);
    for (int i = 0; i < 8; i++)
      add_item(1'b1, 16'h7FFF, 16'h8000, (i % 2) ? 16'h7FFF : 16'h8000);
    add_cfg(CFG_WINDOW_COUNT, 16'd1);
    for (int i = 0; i < 11; i++)
      add_item(1'b1, 16'h7FF0 - 16'(i), 16'h8003 + 16'(i), (i % 2) ? 16'h0000 : 16'hFFFF);

    rm = 16'hFFFF;
    mm = 16'h8000;
    while (stim_items < ITEM_TARGET) begin
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(5))
          0: w = 4'd0;
          1: w = 4'd1;
          2: w = 4'd15;
          default: w = 4'($urandom_range(15));
        endcase
        add_cfg(CFG_WINDOW_COUNT, {12'h000, w});
      end
      if ($urandom_range(2) == 0) begin
        rm = pick_mask();
        add_cfg(CFG_RIGHT_MASK, rm);
      end
      if ($urandom_range(2) == 0) begin
        mm = pick_mask();
        add_cfg(CFG_MIDDLE_MASK, mm);
      end
      case ($urandom_range(4))
        0: trig_pct = 0;
        1: trig_pct = 100;
        2: trig_pct = 30;
        default: trig_pct = 75;
      endcase
      len = $urandom_range(10, 90);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && $urandom_range(3) == 0) add_drain();
        case ($urandom_range(3))
          0: pot = 16'($urandom) & ~rm;
          1: pot = 16'($urandom) & ~mm;
          default: pot = 16'($urandom);
        endcase
        add_item($urandom_range(99) < trig_pct, rand_pos(), rand_pos(), pot);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (steps.size() != 0 || in_valid || n_got != n_sent);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (pending_reports.size() != 0)
      log_error({"missing word: ", show(pending_reports.pop_front())});

    $display("Checked %0d result words, %0d window averages (%0d valid), %0d register writes",
             n_got, n_means, n_valid_means, n_cfg);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== light_pen_window_averager.f =====
rtl/lpwa_pkg.sv
rtl/light_pen_window_averager.sv
tb/tb_top.sv
